// ----- hdl/wtct_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the windowed threshold crossing trigger
package wtct_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SCALED_W = 8;
  localparam int TIME_W   = 32;
  localparam int HOLD_W   = 10;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2048;
  localparam logic                ENABLE_RESET    = 1'b1;
  localparam logic [HOLD_W-1:0]   HOLDOFF_RESET   = 10'd300;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ENABLE    = 2'd1;
  localparam logic [1:0] REG_HOLDOFF   = 2'd2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CHECK  = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample_value;
    logic [TIME_W-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic                event_fired;
    logic                event_rising;
    logic [SAMPLE_W-1:0] latest_raw;
    logic [SCALED_W-1:0] latest_scaled;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic                enable;
    logic [HOLD_W-1:0]   holdoff_ms;
  } cfg_t;

endpackage

// ----- hdl/wtct_regs.sv -----
`timescale 1ns / 1ps
// configuration register file behind the apb port
module wtct_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wtct_pkg::ADDR_W-1:0] paddr,
  input  logic [wtct_pkg::DATA_W-1:0] pwdata,
  output logic [wtct_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output wtct_pkg::cfg_t              cfg
);
  import wtct_pkg::*;

  logic [1:0] reg_index;
  logic       wr_strobe;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_strobe = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= THRESHOLD_RESET;
      cfg.enable     <= ENABLE_RESET;
      cfg.holdoff_ms <= HOLDOFF_RESET;
    end else if (wr_strobe) begin
      unique case (reg_index)
        REG_THRESHOLD: cfg.threshold  <= pwdata[SAMPLE_W-1:0];
        REG_ENABLE:    cfg.enable     <= pwdata[0];
        REG_HOLDOFF:   cfg.holdoff_ms <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_index)
      REG_THRESHOLD: prdata = DATA_W'(cfg.threshold);
      REG_ENABLE:    prdata = DATA_W'(cfg.enable);
      REG_HOLDOFF:   prdata = DATA_W'(cfg.holdoff_ms);
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- hdl/wtct_ring.sv -----
`timescale 1ns / 1ps
// sample ring memory, one write port and one registered read port
module wtct_ring #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [wtct_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [wtct_pkg::SAMPLE_W-1:0] rd_data
);
  import wtct_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/wtct_scale.sv -----
`timescale 1ns / 1ps
// twelve-bit to eight-bit sample scaler, floor(v * 255 / 4095)
module wtct_scale (
  input  logic [wtct_pkg::SAMPLE_W-1:0] raw,
  output logic [wtct_pkg::SCALED_W-1:0] scaled
);
  import wtct_pkg::*;

  localparam int PROD_W = SAMPLE_W + SCALED_W;
  localparam logic [SAMPLE_W:0] DIVISOR = 13'd4095;

  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] q0;
  logic [SAMPLE_W:0]   rem;

  // divide by 2^12 - 1: estimate with a shift, then one correction step
  assign prod   = {raw, {SCALED_W{1'b0}}} - PROD_W'(raw);
  assign q0     = prod[PROD_W-1:SAMPLE_W];
  assign rem    = {1'b0, prod[SAMPLE_W-1:0]} + (SAMPLE_W+1)'(q0);
  assign scaled = (rem >= DIVISOR) ? q0 + 1'b1 : q0;

endmodule

// ----- hdl/windowed_threshold_crossing_trigger_unit.sv -----
`timescale 1ns / 1ps
// top level: sample ring, crossing scan sequencer and result register
// a sample transaction passes from acceptance to the finish state, then to the registered result;
// a check also passes through the prime state and a scan of the filled ring entries, cut short
// when a crossing ends the scan early, skipped when disabled or under two samples
// one transaction at a time, the scan reading one ring entry per cycle; a held result stalls
// the next input
// rst is synchronous and clears control state, times, held sample and config; ring is not cleared
module windowed_threshold_crossing_trigger_unit #(
  parameter int WINDOW_DEPTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  wtct_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wtct_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wtct_pkg::ADDR_W-1:0] paddr,
  input  logic [wtct_pkg::DATA_W-1:0] pwdata,
  output logic [wtct_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import wtct_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PRIME  = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  cfg_t                cfg;
  logic [1:0]          state;
  logic [AW-1:0]       wp;
  logic [CW-1:0]       fill_count;
  logic                above_flag;
  logic [TIME_W-1:0]   last_rise_time;
  logic [TIME_W-1:0]   last_fall_time;
  logic [SAMPLE_W-1:0] held_raw;
  logic [SCALED_W-1:0] held_scaled;
  logic [TIME_W-1:0]   now_q;
  logic [AW-1:0]       scan_ptr;
  logic [CW-1:0]       idx;
  logic [SAMPLE_W-1:0] prev;
  logic                res_fired;
  logic                res_rising;

  logic                full;
  logic [AW-1:0]       start;
  logic [AW-1:0]       rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                wr_en;
  logic [SCALED_W-1:0] in_scaled;
  logic [CW-1:0]       idx_next;
  logic                rise_x;
  logic                fall_x;
  logic                rise_ok;
  logic                fall_ok;
  logic [TIME_W-1:0]   rise_gap;
  logic [TIME_W-1:0]   fall_gap;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  wtct_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wtct_ring #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wp),
    .wr_data (in_data.sample_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wtct_scale u_scale (
    .raw    (in_data.sample_value),
    .scaled (in_scaled)
  );

  assign in_ready = (state == S_IDLE);
  assign full     = (fill_count == CW'(WINDOW_DEPTH));
  assign start    = full ? wp : '0;
  assign rd_addr  = (state == S_IDLE) ? start : scan_ptr;
  assign wr_en    = in_valid && in_ready && (in_data.req_type == REQ_SAMPLE);
  assign idx_next = idx + 1'b1;

  assign rise_x   = (prev <= cfg.threshold) && (rd_data > cfg.threshold);
  assign fall_x   = (prev >= cfg.threshold) && (rd_data < cfg.threshold);
  assign rise_gap = now_q - last_rise_time;
  assign fall_gap = now_q - last_fall_time;
  assign rise_ok  = rise_gap >= TIME_W'(cfg.holdoff_ms);
  assign fall_ok  = fall_gap >= TIME_W'(cfg.holdoff_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      wp             <= '0;
      fill_count     <= '0;
      above_flag     <= 1'b0;
      last_rise_time <= '0;
      last_fall_time <= '0;
      held_raw       <= '0;
      held_scaled    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_fired  <= 1'b0;
            res_rising <= 1'b0;
            now_q      <= in_data.now_ms;
            if (in_data.req_type == REQ_SAMPLE) begin
              held_raw    <= in_data.sample_value;
              held_scaled <= in_scaled;
              wp          <= ptr_inc(wp);
              if (!full) begin
                fill_count <= fill_count + 1'b1;
              end
              state <= S_FINISH;
            end else if (!cfg.enable) begin
              above_flag <= 1'b0;
              state      <= S_FINISH;
            end else if (fill_count < CW'(2)) begin
              state <= S_FINISH;
            end else begin
              scan_ptr <= ptr_inc(start);
              idx      <= CW'(1);
              state    <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          prev     <= rd_data;
          scan_ptr <= ptr_inc(scan_ptr);
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (rise_x) begin
            if (!above_flag && rise_ok) begin
              res_fired      <= 1'b1;
              res_rising     <= 1'b1;
              last_rise_time <= now_q;
              above_flag     <= 1'b1;
            end
            state <= S_FINISH;
          end else if (fall_x) begin
            if (above_flag && fall_ok) begin
              res_fired      <= 1'b1;
              last_fall_time <= now_q;
              above_flag     <= 1'b0;
            end
            state <= S_FINISH;
          end else if (idx_next == fill_count) begin
            // last entry scanned is the newest sample
            above_flag <= (rd_data > cfg.threshold);
            state      <= S_FINISH;
          end else begin
            prev     <= rd_data;
            idx      <= idx_next;
            scan_ptr <= ptr_inc(scan_ptr);
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.event_fired   <= res_fired;
            out_data.event_rising  <= res_rising;
            out_data.latest_raw    <= held_raw;
            out_data.latest_scaled <= held_scaled;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(WINDOW_DEPTH))
    else $error("fill count above ring depth");

  a_wp_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !full |-> (CW'(wp) == fill_count))
    else $error("write pointer out of step with fill count");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx < fill_count))
    else $error("scan index past written entries");

  a_rise_sets_flag: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && res_fired && res_rising) |-> above_flag)
    else $error("rising event without above flag");

  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished transaction not registered");

endmodule

// ----- sim/trigger_checker.sv -----
`timescale 1ns / 1ps
// checker for the trigger unit: tracks config writes, predicts each result and compares
module trigger_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  wtct_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  wtct_pkg::out_item_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [wtct_pkg::ADDR_W-1:0] paddr,
  input  logic [wtct_pkg::DATA_W-1:0] pwdata,
  output int                          mismatches,
  output int                          pending,
  output int                          results_seen,
  output int                          rises_seen,
  output int                          falls_seen
);
  import wtct_pkg::*;

  localparam int DEPTH = 32;
  localparam int PTR_W = $clog2(DEPTH);

  logic [SAMPLE_W-1:0] ring [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W:0]      fill;
  logic                above;
  logic [TIME_W-1:0]   rise_ms;
  logic [TIME_W-1:0]   fall_ms;
  logic [SAMPLE_W-1:0] held_raw;
  logic [SCALED_W-1:0] held_scaled;
  cfg_t                cfg;
  out_item_t           outcome_q [$];

  function automatic out_item_t trigger_outcome(input in_item_t item);
    out_item_t        r;
    logic [PTR_W-1:0] start;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] cur;
    logic [TIME_W-1:0] elapsed;
    logic             crossed;
    int               scaled_full;
    r = '0;
    if (item.req_type == REQ_SAMPLE) begin
      scaled_full = (int'(item.sample_value) * 255) / 4095;
      held_raw = item.sample_value;
      held_scaled = SCALED_W'(scaled_full);
      ring[wr_ptr] = item.sample_value;
      wr_ptr = wr_ptr + 1'b1;
      if (fill < DEPTH) fill = fill + 1'b1;
    end else if (!cfg.enable) begin
      above = 1'b0;
    end else if (fill >= 2) begin
      start = (fill < DEPTH) ? '0 : wr_ptr;
      prev = ring[start];
      crossed = 1'b0;
      for (int i = 1; i < fill && !crossed; i++) begin
        cur = ring[start + PTR_W'(i)];
        if (prev <= cfg.threshold && cur > cfg.threshold) begin
          crossed = 1'b1;
          elapsed = item.now_ms - rise_ms;
          if (!above && elapsed >= TIME_W'(cfg.holdoff_ms)) begin
            r.event_fired = 1'b1;
            r.event_rising = 1'b1;
            rise_ms = item.now_ms;
            above = 1'b1;
          end
        end else if (prev >= cfg.threshold && cur < cfg.threshold) begin
          crossed = 1'b1;
          elapsed = item.now_ms - fall_ms;
          if (above && elapsed >= TIME_W'(cfg.holdoff_ms)) begin
            r.event_fired = 1'b1;
            fall_ms = item.now_ms;
            above = 1'b0;
          end
        end
        prev = cur;
      end
      if (!crossed) above = ring[wr_ptr - 1'b1] > cfg.threshold;
    end
    r.latest_raw = held_raw;
    r.latest_scaled = held_scaled;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      wr_ptr = '0;
      fill = '0;
      above = 1'b0;
      rise_ms = '0;
      fall_ms = '0;
      held_raw = '0;
      held_scaled = '0;
      cfg = '{THRESHOLD_RESET, ENABLE_RESET, HOLDOFF_RESET};
      outcome_q.delete();
      mismatches = 0;
      results_seen = 0;
      rises_seen = 0;
      falls_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_THRESHOLD: cfg.threshold = pwdata[SAMPLE_W-1:0];
          REG_ENABLE:    cfg.enable = pwdata[0];
          REG_HOLDOFF:   cfg.holdoff_ms = pwdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.event_fired === 1'b1) begin
          if (out_data.event_rising === 1'b1) rises_seen++;
          else falls_seen++;
        end
        if (outcome_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: fired=%0d rising=%0d raw=%0d scaled=%0d",
                     $time, out_data.event_fired, out_data.event_rising,
                     out_data.latest_raw, out_data.latest_scaled);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (out_data.event_fired !== want.event_fired ||
              out_data.event_rising !== want.event_rising ||
              out_data.latest_raw !== want.latest_raw ||
              out_data.latest_scaled !== want.latest_scaled) begin
            if (mismatches < 10)
              $display({"%0t: mismatch expected fired=%0d rising=%0d raw=%0d scaled=%0d",
                        ", got fired=%0d rising=%0d raw=%0d scaled=%0d"},
                       $time, want.event_fired, want.event_rising, want.latest_raw,
                       want.latest_scaled, out_data.event_fired, out_data.event_rising,
                       out_data.latest_raw, out_data.latest_scaled);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) outcome_q.push_back(trigger_outcome(in_data));
    end
    pending <= outcome_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// testbench top: clock, reset, stimulus, config writes and verdict for the trigger unit
module tb;
  import wtct_pkg::*;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                pending;
  int                results_seen;
  int                rises_seen;
  int                falls_seen;
  int                items_sent;
  int                results_taken;
  int                settings_used;
  logic [TIME_W-1:0] clock_ms;
  logic [SAMPLE_W-1:0] level;

  windowed_threshold_crossing_trigger_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  trigger_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .results_seen(results_seen),
    .rises_seen  (rises_seen),
    .falls_seen  (falls_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input in_item_t item);
    int gap;
    gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    in_item_t item;
    item = '0;
    item.req_type = REQ_SAMPLE;
    item.sample_value = value;
    item.now_ms = TIME_W'($urandom);
    send_item(item);
  endtask

  task automatic send_check(input logic [TIME_W-1:0] stamp);
    in_item_t item;
    item = '0;
    item.req_type = REQ_CHECK;
    item.sample_value = SAMPLE_W'($urandom);
    item.now_ms = stamp;
    send_item(item);
  endtask

  task automatic apb_write(input logic [1:0] reg_index, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // drain the unit, then rewrite all three registers
  task automatic apply_settings(input logic [SAMPLE_W-1:0] thr, input logic en,
                                input logic [HOLD_W-1:0] hold);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    apb_write(REG_THRESHOLD, DATA_W'(thr));
    apb_write(REG_ENABLE, DATA_W'(en));
    apb_write(REG_HOLDOFF, DATA_W'(hold));
    level = thr;
    settings_used++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0, 1: v = int'(level) + int'($urandom_range(0, 128)) - 64;
      2: v = $urandom_range(0, 1) ? $urandom_range(0, level) : $urandom_range(level, 4095);
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // mostly bursts of samples around the threshold closed by a check, some lone noise
  task automatic random_items(input int count);
    int n;
    int burst;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) send_sample(SAMPLE_W'($urandom));
        else send_check(TIME_W'($urandom));
        n++;
      end else begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst; k++) send_sample(pick_sample());
        if ($urandom_range(0, 15) == 0) clock_ms = TIME_W'($urandom);
        else clock_ms = clock_ms + TIME_W'($urandom_range(0, 1200));
        send_check(clock_ms);
        n += burst + 1;
      end
    end
  endtask

  // receiver with random stalls and two long hold-offs
  initial begin
    int gap;
    out_ready <= 1'b0;
    results_taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (results_taken == 60 || results_taken == 250) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      gap = ((results_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    items_sent = 0;
    settings_used = 0;
    clock_ms = TIME_W'($urandom);
    level = THRESHOLD_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty ring, single sample, holdoff edge, threshold-equal samples, timestamp wrap
    send_check(32'd0);
    send_sample(12'd0);
    send_check(32'd5);
    send_sample(12'hFFF);
    send_check(32'd299);
    send_check(32'd300);
    send_sample(12'd2048);
    send_sample(12'd2047);
    send_check(32'hFFFF_FFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_check(32'h0000_0010);

    apply_settings(12'd0, 1'b1, 10'd0);
    send_sample(12'd0);
    send_sample(12'd1);
    send_check(32'h8000_0000);

    apply_settings(12'd2048, 1'b0, 10'd1023);
    send_check(32'h7FFF_FFFF);
    send_sample(12'd3000);
    send_check(32'hFFFF_FFFE);

    apply_settings(12'd0, 1'b1, 10'd1023);
    random_items(62);
    apply_settings(12'd4095, 1'b1, 10'd0);
    random_items(62);
    apply_settings(12'd2048, 1'b0, 10'd300);
    random_items(62);
    apply_settings(12'd1000, 1'b1, 10'd1000);
    random_items(62);
    apply_settings(SAMPLE_W'($urandom_range(0, 4095)), 1'b1, HOLD_W'($urandom_range(0, 1023)));
    random_items(62);
    apply_settings(12'd3000, 1'b1, 10'd300);
    random_items(62);
    apply_settings(12'd2048, 1'b1, 10'd300);
    random_items(62);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d input transactions across %0d register settings", items_sent,
             settings_used);
    $display("checked %0d results, %0d rising and %0d falling events", results_seen,
             rises_seen, falls_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/wtct_pkg.sv
hdl/wtct_regs.sv
hdl/wtct_ring.sv
hdl/wtct_scale.sv
hdl/windowed_threshold_crossing_trigger_unit.sv
sim/trigger_checker.sv
sim/tb.sv
